@@ sv/tbrr_pkg.sv @@
// Package for the token bucket round-robin scheduler.
// Types, codes and constants shared by the top, front and back modules; no dependencies.
package tbrr_pkg;
  localparam int MAX_AGENTS_DEF = 8;
  localparam int BUCKET_SECONDS_DEF = 10;
  localparam int TICKS_PER_SECOND_DEF = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REQ_LAUNCH = 3'd0;
  localparam logic [2:0] REQ_TICK = 3'd1;
  localparam logic [2:0] REQ_REGISTER = 3'd2;
  localparam logic [2:0] REQ_UNREGISTER = 3'd3;
  localparam logic [2:0] REQ_ROTATE = 3'd4;
  localparam logic [2:0] REQ_QUERY = 3'd5;
  localparam logic [2:0] REQ_NONE = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  localparam logic CFG_TIMESLICE = 1'b0;
  localparam logic CFG_DEFAULT_RATE = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] agent_key;
    logic [15:0] priority_req;
    logic [15:0] rate;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        launch_ok;
    logic [19:0] tokens_left;
    logic [9:0]  wait_ms;
    logic [6:0]  share_pct;
    logic        holder_valid;
    logic [2:0]  holder_index;
    logic [31:0] launched_count;
    logic [31:0] blocked_count;
    logic [31:0] rotation_count;
    logic [3:0]  agents_in_use;
  } rsp_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

@@ sv/tbrr_if.sv @@
// Valid/ready channel interface carrying one payload.
// Payload type is a parameter; used with tbrr_pkg structs.
interface tbrr_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/token_bucket_round_robin_scheduler.sv @@
// Top level of the token bucket round-robin scheduler.
// Depends on tbrr_pkg, tbrr_if, tbrr_front and tbrr_back.
// One request is carried out at a time: a key search over the table (one slot
// a cycle), the operation (a tick or an unregister sweeps the table one slot a
// cycle), a second search that sums priorities, then two serial divisions for
// wait time and share. The next request starts once the response is taken.
// A two-entry queue takes new requests while one is at work.
module token_bucket_round_robin_scheduler #(
  parameter int MAX_AGENTS = tbrr_pkg::MAX_AGENTS_DEF,
  parameter int BUCKET_SECONDS = tbrr_pkg::BUCKET_SECONDS_DEF,
  parameter int TICKS_PER_SECOND = tbrr_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  tbrr_if.sink        req_ch,
  tbrr_if.source      rsp_ch
);
  import tbrr_pkg::*;
  logic q_valid, q_ready;
  req_t q_data;

  tbrr_front u_front (
    .clk(clk), .rst(rst), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_data(req_ch.data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  tbrr_back #(
    .MAX_AGENTS(MAX_AGENTS), .BUCKET_SECONDS(BUCKET_SECONDS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp_ch.data)
  );
endmodule

@@ sv/tbrr_front.sv @@
// Front end: accepts requests and queues them for the engine.
// Depends on tbrr_pkg.
module tbrr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tbrr_pkg::req_t in_data,
  output logic           q_valid,
  input  logic           q_ready,
  output tbrr_pkg::req_t q_data
);
  import tbrr_pkg::*;
  localparam int AW = $clog2(QUEUE_DEPTH);
  req_t mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic push, pop;
  req_t clean;

  // map request codes above query to none: they only yield status ok
  always_comb begin
    clean = in_data;
    if (in_data.req_type > REQ_QUERY) clean.req_type = REQ_NONE;
  end
  assign in_ready = (count != (AW+1)'(QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= clean;
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ sv/tbrr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module tbrr_div #(parameter int W = 24) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  logic [W-1:0] rem, q;
  logic [W-1:0] dv;
  logic [$clog2(W+1)-1:0] cnt;
  logic busy;
  logic [W:0] trial;
  assign trial = {rem, q[W-1]} - {1'b0, dv};
  assign quo = q;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; q <= num; dv <= den; rem <= '0;
        cnt <= ($clog2(W+1))'(W);
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0]; q <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]}; q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/tbrr_back.sv @@
// Back end: agent table, token buckets, holder rotation and result build.
// Depends on tbrr_pkg and tbrr_div.
module tbrr_back #(
  parameter int MAX_AGENTS = tbrr_pkg::MAX_AGENTS_DEF,
  parameter int BUCKET_SECONDS = tbrr_pkg::BUCKET_SECONDS_DEF,
  parameter int TICKS_PER_SECOND = tbrr_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           q_valid,
  output logic           q_ready,
  input  tbrr_pkg::req_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tbrr_pkg::rsp_t out_data
);
  import tbrr_pkg::*;
  localparam int SW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CW = $clog2(MAX_AGENTS + 1);
  localparam int PW = 16 + $clog2(MAX_AGENTS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SWEEP  = 7'b0001000,
    S_FIND   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  logic [15:0] slot_key [MAX_AGENTS];
  logic [15:0] slot_priority [MAX_AGENTS];
  logic [15:0] slot_rate [MAX_AGENTS];
  logic [19:0] slot_bucket_limit [MAX_AGENTS];
  logic [19:0] slot_tokens [MAX_AGENTS];
  logic [3:0]  slot_refill_ticks [MAX_AGENTS];
  logic [31:0] slot_launched [MAX_AGENTS];
  logic [31:0] slot_blocked [MAX_AGENTS];

  logic [CW-1:0] agent_total;
  logic [SW-1:0] holder_slot;
  logic holder_present;
  logic [15:0] slice_elapsed, timeslice_ticks, default_rate;
  logic [31:0] rotations;

  state_t state;
  req_t req;
  logic [CW-1:0] idx;
  logic found;
  logic [SW-1:0] fslot;
  logic [2:0] status;
  logic [PW-1:0] psum;
  logic div_phase;
  logic [23:0] div_num, div_den, div_q;
  logic div_start, div_done, div_go;
  logic [9:0] wait_r;
  logic [SW-1:0] ix;
  logic [15:0] eff;
  logic [19:0] lim;
  logic [20:0] refill;

  assign ix = idx[SW-1:0];
  assign eff = (req.rate != 16'd0) ? req.rate : default_rate;
  assign lim = 20'(eff * BUCKET_SECONDS);
  assign refill = {1'b0, slot_tokens[ix]} + 21'(slot_rate[ix]);
  assign q_ready = (state == S_IDLE) && !out_valid;

  // start the wait division when the final scan ends, the share division after it
  assign div_go = ((state == S_FIND) && (idx >= agent_total)) ||
                  ((state == S_DIV) && div_done && !div_phase);

  tbrr_div #(.W(24)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else div_start <= div_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      agent_total <= '0; holder_slot <= '0; holder_present <= 1'b0;
      slice_elapsed <= '0; rotations <= '0;
      timeslice_ticks <= 16'd10; default_rate <= 16'd100;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMESLICE) timeslice_ticks <= cfg_data;
        else default_rate <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            req <= q_data; idx <= '0; found <= 1'b0; fslot <= '0;
            status <= ST_OK; state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // scan one slot a cycle for the key
          if (idx < agent_total && !found) begin
            if (slot_key[ix] == req.agent_key) begin
              found <= 1'b1; fslot <= ix;
            end
            idx <= idx + 1'b1;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (req.req_type == REQ_TICK ||
                    (req.req_type == REQ_UNREGISTER && found)) ? S_SWEEP : S_FIND;
          idx <= (req.req_type == REQ_UNREGISTER && found) ? CW'(fslot) : '0;
          found <= 1'b0;
          case (req.req_type)
            REQ_LAUNCH: begin
              if (!found) status <= ST_NOT_FOUND;
              else if (slot_tokens[fslot] == '0) begin
                slot_blocked[fslot] <= sat_inc32(slot_blocked[fslot]);
                status <= ST_BLOCKED;
              end else begin
                slot_tokens[fslot] <= slot_tokens[fslot] - 1'b1;
                slot_launched[fslot] <= sat_inc32(slot_launched[fslot]);
              end
            end
            REQ_TICK: ;
            REQ_REGISTER: begin
              if (found) begin
                slot_priority[fslot] <= req.priority_req;
                slot_rate[fslot] <= eff; slot_bucket_limit[fslot] <= lim;
              end else if (agent_total >= CW'(MAX_AGENTS)) begin
                status <= ST_FULL;
              end else begin
                slot_key[agent_total[SW-1:0]] <= req.agent_key;
                slot_priority[agent_total[SW-1:0]] <= req.priority_req;
                slot_rate[agent_total[SW-1:0]] <= eff;
                slot_bucket_limit[agent_total[SW-1:0]] <= lim;
                slot_tokens[agent_total[SW-1:0]] <= lim;
                slot_refill_ticks[agent_total[SW-1:0]] <= '0;
                slot_launched[agent_total[SW-1:0]] <= '0;
                slot_blocked[agent_total[SW-1:0]] <= '0;
                agent_total <= agent_total + 1'b1;
                if (!holder_present) begin
                  holder_present <= 1'b1; holder_slot <= '0;
                end
              end
            end
            REQ_UNREGISTER: if (!found) status <= ST_NOT_FOUND;
            REQ_ROTATE: begin
              if (agent_total <= CW'(1)) status <= ST_REFUSED;
              else begin
                holder_slot <= (CW'(holder_slot) + 1'b1 >= agent_total) ? '0
                               : holder_slot + 1'b1;
                rotations <= sat_inc32(rotations);
                slice_elapsed <= '0;
              end
            end
            REQ_QUERY: if (!found) status <= ST_NOT_FOUND;
            default: ;
          endcase
        end
        S_SWEEP: begin
          if (req.req_type == REQ_TICK) begin
            // refill one slot a cycle, then advance the timeslice
            if (idx < agent_total) begin
              if (slot_refill_ticks[ix] + 1'b1 >= 4'(TICKS_PER_SECOND)) begin
                slot_refill_ticks[ix] <= '0;
                slot_tokens[ix] <= (refill > {1'b0, slot_bucket_limit[ix]}) ?
                                   slot_bucket_limit[ix] : refill[19:0];
              end else begin
                slot_refill_ticks[ix] <= slot_refill_ticks[ix] + 1'b1;
              end
              idx <= idx + 1'b1;
            end else begin
              if ((slice_elapsed + (slice_elapsed != 16'hFFFF) >= timeslice_ticks)
                  && agent_total != '0) begin
                slice_elapsed <= '0;
                holder_slot <= !holder_present ? '0 :
                  ((CW'(holder_slot) + 1'b1 >= agent_total) ? '0 : holder_slot + 1'b1);
                holder_present <= 1'b1;
                rotations <= sat_inc32(rotations);
              end else if (slice_elapsed != 16'hFFFF) begin
                slice_elapsed <= slice_elapsed + 1'b1;
              end
              idx <= '0; found <= 1'b0; state <= S_FIND;
            end
          end else begin
            // compact the table down over the removed slot
            if (idx + 1'b1 < agent_total) begin
              slot_key[ix] <= slot_key[ix+1'b1];
              slot_priority[ix] <= slot_priority[ix+1'b1];
              slot_rate[ix] <= slot_rate[ix+1'b1];
              slot_bucket_limit[ix] <= slot_bucket_limit[ix+1'b1];
              slot_tokens[ix] <= slot_tokens[ix+1'b1];
              slot_refill_ticks[ix] <= slot_refill_ticks[ix+1'b1];
              slot_launched[ix] <= slot_launched[ix+1'b1];
              slot_blocked[ix] <= slot_blocked[ix+1'b1];
              idx <= idx + 1'b1;
            end else begin
              agent_total <= agent_total - 1'b1;
              if (agent_total == CW'(1)) begin
                holder_present <= 1'b0; holder_slot <= '0;
              end else if (CW'(holder_slot) >= agent_total - 1'b1) begin
                holder_slot <= SW'(agent_total - 2'd2);
              end
              idx <= '0; found <= 1'b0; state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          // re-search the key after the change and sum priorities
          if (idx < agent_total) begin
            if (slot_key[ix] == req.agent_key && !found) begin
              found <= 1'b1; fslot <= ix;
            end
            psum <= ((idx == '0) ? '0 : psum) + PW'(slot_priority[ix]);
            idx <= idx + 1'b1;
          end else begin
            if (agent_total == '0) psum <= '0;
            div_phase <= 1'b0;
            div_num <= 24'(slot_rate[fslot] == '0 ? 16'd1 : 16'd1000);
            div_den <= (slot_rate[fslot] == '0) ? 24'd1 : 24'(slot_rate[fslot]);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!div_phase) begin
              wait_r <= (slot_rate[fslot] == '0) ? 10'd1000 : div_q[9:0];
              div_phase <= 1'b1;
              div_num <= 24'(slot_priority[fslot]) * 24'd100;
              div_den <= (psum == '0) ? 24'd1 : 24'(psum);
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data.status <= status;
          out_data.holder_valid <= holder_present;
          out_data.holder_index <= 3'(holder_slot);
          out_data.rotation_count <= rotations;
          out_data.agents_in_use <= 4'(agent_total);
          out_data.launch_ok <= found && slot_tokens[fslot] != '0;
          out_data.tokens_left <= found ? slot_tokens[fslot] : '0;
          out_data.wait_ms <= (found && slot_tokens[fslot] == '0) ? wait_r : '0;
          out_data.share_pct <= (found && psum != '0) ? div_q[6:0] : '0;
          out_data.launched_count <= found ? slot_launched[fslot] : '0;
          out_data.blocked_count <= found ? slot_blocked[fslot] : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
